>>> hw/rtl/spb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the scalar parameter blend block.
// Used by the channel interfaces and by the top level; no dependencies.
package spb_pkg;

    // Field widths of the items and the running state.
    localparam int VAL_W      = 32;
    localparam int SUM_W      = 48;
    localparam int TIME_W     = 32;
    localparam int COUNT_BITS_DEF = 16;

    // Configuration port geometry.
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 4;

    // One in unsigned Q16.16, and the width that holds it.
    localparam int ONE_W = 17;
    localparam logic [ONE_W-1:0] ONE_Q16 = 17'h10000;

    // Item commands.
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_SYNC = 1'b1;

    // Blend modes: off, and the mode that seeds the frame sum with the default value.
    localparam logic [1:0] MODE_OFF          = 2'd0;
    localparam logic [1:0] MODE_SEED_DEFAULT = 2'd2;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_SMOOTH_ENABLE = 2'd0,
        REG_BLEND_MODE    = 2'd1,
        REG_DEFAULT_VALUE = 2'd2,
        REG_TIME_SCALE    = 2'd3
    } t_reg_idx;

endpackage

>>> hw/rtl/spb_in_if.sv
`timescale 1ns / 1ps
// Input channel of the scalar parameter blend block: valid/ready and the item fields.
// Depends on spb_pkg for the field widths.
interface spb_in_if;
    import spb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [VAL_W-1:0]  set_value;
    logic                     force_req;
    logic [TIME_W-1:0]        frame_time;

    modport source (output valid, output cmd, output set_value, output force_req,
                    output frame_time, input ready);
    modport sink   (input valid, input cmd, input set_value, input force_req,
                    input frame_time, output ready);
endinterface

>>> hw/rtl/spb_out_if.sv
`timescale 1ns / 1ps
// Output channel of the scalar parameter blend block: valid/ready and the result field.
// Depends on spb_pkg for the field width.
interface spb_out_if;
    import spb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [VAL_W-1:0]  current_value;

    modport source (output valid, output current_value, input ready);
    modport sink   (input valid, input current_value, output ready);
endinterface

>>> hw/rtl/spb_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: signed dividend by unsigned nonzero divisor,
// quotient truncated toward zero. Standalone, no package dependency.
module spb_div #(
    parameter int D_W = 48,
    parameter int C_W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [D_W-1:0] i_dividend,
    input  logic [C_W-1:0]        i_divisor,
    output logic                  o_busy,
    output logic signed [D_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(D_W + 1);

    logic [D_W-1:0]   r_q, n_q;
    logic [C_W-1:0]   r_rem, n_rem;
    logic [C_W-1:0]   r_div, n_div;
    logic             r_neg, n_neg;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [C_W:0]     w_sh;
    logic [C_W:0]     w_diff;
    logic             w_ge;

    // One quotient bit per cycle: shift in the next dividend bit, try a subtract.
    always_comb begin
        w_sh   = {r_rem, r_q[D_W-1]};
        w_diff = w_sh - {1'b0, r_div};
        w_ge   = (w_sh >= {1'b0, r_div});
    end

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_neg  = i_dividend[D_W-1];
            n_q    = i_dividend[D_W-1] ? D_W'(-i_dividend) : D_W'(i_dividend);
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = CNT_W'(D_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_q    = {r_q[D_W-2:0], w_ge};
            n_rem  = w_ge ? w_diff[C_W-1:0] : w_sh[C_W-1:0];
            n_cnt  = r_cnt - CNT_W'(1);
            n_busy = (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? D_W'(-r_q) : D_W'(r_q);

endmodule

>>> hw/rtl/spb_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, unsigned, one multiplier bit per cycle.
// After n steps the product sits shifted left by B_W - n. No package dependency.
module spb_mul #(
    parameter  int A_W = 49,
    parameter  int B_W = 32,
    localparam int N_W = $clog2(B_W + 1),
    localparam int P_W = A_W + B_W + 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    input  logic [N_W-1:0] i_nbits,
    output logic           o_busy,
    output logic [P_W-1:0] o_prod
);
    logic [A_W-1:0] r_a, n_a;
    logic [P_W-1:0] r_p, n_p;
    logic [N_W-1:0] r_cnt, n_cnt;
    logic           r_busy, n_busy;
    logic [A_W:0]   w_hi;

    // Upper part accumulates the multiplicand when the low bit is set.
    always_comb begin
        w_hi = r_p[P_W-1:B_W] + (r_p[0] ? {1'b0, r_a} : '0);
    end

    always_comb begin
        n_a    = r_a;
        n_p    = r_p;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_a    = i_a;
            n_p    = {(A_W + 1)'(0), i_b};
            n_cnt  = i_nbits;
            n_busy = (i_nbits != '0);
        end else if (r_busy) begin
            n_p    = {1'b0, w_hi, r_p[B_W-1:1]};
            n_cnt  = r_cnt - N_W'(1);
            n_busy = (r_cnt != N_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_p <= n_p;
    end

    assign o_busy = r_busy;
    assign o_prod = r_p;

endmodule

>>> hw/rtl/scalar_param_blend_core.sv
`timescale 1ns / 1ps
// Top level of the scalar parameter blend block: APB registers, item sequencer,
// state registers. Depends on spb_pkg, spb_in_if, spb_out_if, spb_div and spb_mul.
//
// Usage:
//   i_in carries set items (cmd 0) and end-of-frame sync items (cmd 1); o_out
//   returns one item per input item holding the parameter value it leaves behind.
//   Both use valid/ready; an item moves when valid and ready are high at a clock edge.
//   The APB port holds smooth_enable, blend_mode, default_value and time_scale at
//   byte addresses 0, 4, 8 and 12; write them only while the block is idle.
//   A set item, or a sync item while blending is off, shows up on o_out in the
//   cycle after it is accepted. A sync item while blending runs the 48-step
//   bit-serial divider (beside the 32-step frame_time * time_scale multiply),
//   a preparation state and a 17-step multiply for the blend step; the divider
//   is skipped when the frame count is zero.
//   Throughput is one item at a time; i_in.ready is high in the idle state when
//   the output register is empty or being emptied.
//   A result waits in the output register while o_out.ready is low; the block then
//   holds off further items that would need the register.
//   Reset (i_rst_n low, synchronous) clears the value, sum, count and registers,
//   and sets time_scale to 1.0.
module scalar_param_blend_core #(
    parameter int COUNT_BITS = spb_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    spb_in_if.sink                       i_in,
    spb_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [spb_pkg::PADDR_W-1:0]  paddr,
    input  logic [spb_pkg::PDATA_W-1:0]  pwdata,
    output logic [spb_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import spb_pkg::*;

    // Shared multiplier geometry: magnitude of a difference by a 32-bit operand.
    localparam int MAG_W   = SUM_W + 1;
    localparam int MUL_B_W = TIME_W;
    localparam int MUL_N_W = $clog2(MUL_B_W + 1);
    localparam int MUL_P_W = MAG_W + MUL_B_W + 1;
    localparam int STEP_W  = MAG_W + 1;
    // A ONE_W-step multiply leaves the product shifted left by MUL_B_W - ONE_W;
    // the blend step drops a further 16 fraction bits.
    localparam int STEP_LSB = MUL_B_W - ONE_W + 16;
    localparam int NEW_W    = STEP_W + 2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_PREP = 4'b0100,
        ST_MUL  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic                    r_smooth_en;
    logic [1:0]              r_blend_mode;
    logic signed [VAL_W-1:0] r_default;
    logic [TIME_W-1:0]       r_time_scale;

    // Parameter state.
    logic signed [VAL_W-1:0] r_pv, n_pv;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [COUNT_BITS-1:0]   r_count, n_count;

    // Sequencer working registers.
    logic                    r_do_div, n_do_div;
    logic [ONE_W-1:0]        r_t, n_t;
    logic                    r_dneg, n_dneg;

    // Output register.
    logic                    r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0] r_out_value, n_out_value;

    logic                    w_cfg_wr;
    t_reg_idx                w_reg;
    logic                    w_blending;
    logic                    w_slot;
    logic                    w_accept;
    logic signed [SUM_W-1:0] w_seed;
    logic signed [SUM_W-1:0] w_base;
    logic [SUM_W:0]          w_add;
    logic signed [SUM_W-1:0] w_add_sat;
    logic [COUNT_BITS:0]     w_cnt_add;
    logic [COUNT_BITS:0]     w_cnt_inc;

    logic                    w_div_start;
    logic                    w_div_busy;
    logic signed [SUM_W-1:0] w_div_quot;

    logic                    w_mul_start;
    logic [MAG_W-1:0]        w_mul_a;
    logic [MUL_B_W-1:0]      w_mul_b;
    logic [MUL_N_W-1:0]      w_mul_n;
    logic                    w_mul_busy;
    logic [MUL_P_W-1:0]      w_mul_prod;

    logic [VAL_W-1:0]        w_tq;
    logic                    w_t_clamp;
    logic [MAG_W-1:0]        w_diff;
    logic [MAG_W-1:0]        w_mag;
    logic [STEP_W-1:0]       w_step;
    logic [NEW_W-1:0]        w_new;
    logic signed [VAL_W-1:0] w_new_sat;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_reg    = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (w_reg)
            REG_SMOOTH_ENABLE: prdata = PDATA_W'(r_smooth_en);
            REG_BLEND_MODE:    prdata = PDATA_W'(r_blend_mode);
            REG_DEFAULT_VALUE: prdata = PDATA_W'(r_default);
            REG_TIME_SCALE:    prdata = PDATA_W'(r_time_scale);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth_en  <= 1'b0;
            r_blend_mode <= MODE_OFF;
            r_default    <= '0;
            r_time_scale <= TIME_W'(ONE_Q16);
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_SMOOTH_ENABLE: r_smooth_en  <= pwdata[0];
                REG_BLEND_MODE:    r_blend_mode <= pwdata[1:0];
                REG_DEFAULT_VALUE: r_default    <= VAL_W'(pwdata);
                REG_TIME_SCALE:    r_time_scale <= TIME_W'(pwdata);
                default:           r_smooth_en  <= r_smooth_en;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign w_blending = r_smooth_en && (r_blend_mode != MODE_OFF);
    assign w_slot     = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && w_slot;
    assign w_accept   = i_in.valid && i_in.ready;

    // ---------------- set item arithmetic ----------------
    // Seed the sum on the first sample of a frame, then add with 48-bit saturation.
    always_comb begin
        w_seed    = (r_blend_mode == MODE_SEED_DEFAULT) ? SUM_W'(r_default) : '0;
        w_base    = (r_count == '0) ? w_seed : r_sum;
        w_add     = {w_base[SUM_W-1], w_base} + (SUM_W + 1)'(i_in.set_value);
        if (w_add[SUM_W] != w_add[SUM_W-1]) begin
            w_add_sat = w_add[SUM_W] ? {1'b1, (SUM_W - 1)'(0)} : {1'b0, {(SUM_W - 1){1'b1}}};
        end else begin
            w_add_sat = w_add[SUM_W-1:0];
        end
        // A nonzero seed counts as one sample of its own.
        w_cnt_inc = ((r_count == '0) && (w_seed != '0)) ? (COUNT_BITS + 1)'(2)
                                                      : (COUNT_BITS + 1)'(1);
        w_cnt_add = {1'b0, r_count} + w_cnt_inc;
    end

    // ---------------- serial units ----------------
    assign w_div_start = w_accept && (i_in.cmd == CMD_SYNC) && w_blending && (r_count != '0);

    spb_div #(
        .D_W (SUM_W),
        .C_W (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_quot)
    );

    // The multiplier first forms frame_time * time_scale, then |target - value| * t.
    always_comb begin
        w_diff = {r_sum[SUM_W-1], r_sum} - MAG_W'(r_pv);
        w_mag  = w_diff[MAG_W-1] ? MAG_W'(-w_diff) : w_diff;
        if (r_state == ST_IDLE) begin
            w_mul_start = w_accept && (i_in.cmd == CMD_SYNC) && w_blending;
            w_mul_a     = MAG_W'(r_time_scale);
            w_mul_b     = i_in.frame_time;
            w_mul_n     = MUL_N_W'(MUL_B_W);
        end else begin
            w_mul_start = (r_state == ST_PREP);
            w_mul_a     = w_mag;
            w_mul_b     = MUL_B_W'(r_t);
            w_mul_n     = MUL_N_W'(ONE_W);
        end
    end

    spb_mul #(
        .A_W (MAG_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_nbits (w_mul_n),
        .o_busy  (w_mul_busy),
        .o_prod  (w_mul_prod)
    );

    // Blend factor: Q32.32 product truncated to Q16.16 and clamped to one.
    always_comb begin
        w_tq      = w_mul_prod[16 +: VAL_W];
        w_t_clamp = (|w_mul_prod[2*VAL_W-1:VAL_W+16]) || (w_tq > VAL_W'(ONE_Q16));
    end

    // New value: value plus the signed step, saturated to 32 bits.
    always_comb begin
        w_step = w_mul_prod[STEP_LSB +: STEP_W];
        w_new  = NEW_W'(r_pv) + (r_dneg ? NEW_W'(-{2'b00, w_step}) : {2'b00, w_step});
        if (w_new[NEW_W-1]) begin
            w_new_sat = (&w_new[NEW_W-2:VAL_W-1]) ? w_new[VAL_W-1:0]
                                                  : {1'b1, (VAL_W - 1)'(0)};
        end else begin
            w_new_sat = (|w_new[NEW_W-2:VAL_W-1]) ? {1'b0, {(VAL_W - 1){1'b1}}}
                                                  : w_new[VAL_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_pv        = r_pv;
        n_sum       = r_sum;
        n_count     = r_count;
        n_do_div    = r_do_div;
        n_t         = r_t;
        n_dneg      = r_dneg;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_value = r_out_value;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    if (i_in.cmd == CMD_SET) begin
                        if (w_blending && !i_in.force_req) begin
                            n_sum   = w_add_sat;
                            n_count = w_cnt_add[COUNT_BITS] ? '1 : w_cnt_add[COUNT_BITS-1:0];
                        end else if (w_blending) begin
                            n_pv    = i_in.set_value;
                            n_sum   = SUM_W'(i_in.set_value);
                            n_count = '0;
                        end else begin
                            n_pv    = i_in.set_value;
                        end
                        n_out_value = n_pv;
                    end else if (w_blending) begin
                        // Sync while blending: result comes at the end of the run.
                        n_out_valid = r_out_valid && !o_out.ready;
                        n_do_div    = (r_count != '0);
                        n_state     = ST_DIV;
                    end else begin
                        n_out_value = r_pv;
                    end
                end
            end
            ST_DIV: begin
                if (!w_div_busy && !w_mul_busy) begin
                    if (r_do_div) begin
                        n_sum   = w_div_quot;
                        n_count = '0;
                    end
                    n_t     = w_t_clamp ? ONE_Q16 : w_tq[ONE_W-1:0];
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_dneg  = w_diff[MAG_W-1];
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (!w_mul_busy && w_slot) begin
                    n_pv        = w_new_sat;
                    n_out_valid = 1'b1;
                    n_out_value = w_new_sat;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pv        <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_do_div    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pv        <= n_pv;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_do_div    <= n_do_div;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t         <= n_t;
        r_dneg      <= n_dneg;
        r_out_value <= n_out_value;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.current_value = r_out_value;

endmodule
